// ===== design/abx_pkg.sv =====
// Shared types, constant text tables and helper functions for the abbreviation expander.
// Used by every module of the block; depends on nothing.
`default_nettype none

package abx_pkg;

  localparam int NUM_ABBREV  = 9;
  localparam int ABBR_MAX    = 8;
  localparam int FULL_MAX    = 13;
  localparam int IDX_W       = 4;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [ABBR_MAX*8-1:0] ABBR_TXT [NUM_ABBREV] = '{
    "facsims.", "facsim.", "ports.", "port.", "ill.", "col.", "ed.", "v.", "p."
  };
  localparam logic [POS_W-1:0] ABBR_LEN [NUM_ABBREV] = '{
    4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd2, 4'd2
  };
  localparam logic [FULL_MAX*8-1:0] FULL_TXT [NUM_ABBREV] = '{
    "facsimiles", "facsimile", "portraits", "portrait", "illustrations",
    "color", "edition", "volumes", "pages"
  };
  localparam logic [POS_W-1:0] FULL_LEN [NUM_ABBREV] = '{
    4'd10, 4'd9, 4'd9, 4'd8, 4'd13, 4'd5, 4'd7, 4'd7, 4'd5
  };

  typedef struct packed {
    logic       expand;
    logic [7:0] data;
    logic       last;
  } abx_tok_t;

  typedef struct packed {
    logic             undecided;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } abx_judge_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [7:0] abbr_char(input logic [IDX_W-1:0] k,
                                           input logic [POS_W-1:0] j);
    logic [ABBR_MAX*8-1:0] s;
    int                    sh;
    s  = ABBR_TXT[k];
    sh = 8 * (int'(ABBR_LEN[k]) - 1 - int'(j));
    if (sh < 0) begin
      return 8'h00;
    end
    return s[sh +: 8];
  endfunction

  function automatic logic [7:0] full_char(input logic [IDX_W-1:0] k,
                                           input logic [POS_W-1:0] p);
    logic [FULL_MAX*8-1:0] s;
    int                    sh;
    s  = FULL_TXT[k];
    sh = 8 * (int'(FULL_LEN[k]) - 1 - int'(p));
    if (sh < 0) begin
      return 8'h00;
    end
    return s[sh +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== design/abx_if.sv =====
// Byte stream channel interfaces for the abbreviation expander input and result sides.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface abx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_in;
  modport source(output valid, output char_in, output last_in, input ready);
  modport sink(input valid, input char_in, input last_in, output ready);
endinterface

interface abx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_out;
  modport source(output valid, output char_out, output last_out, input ready);
  modport sink(input valid, input char_out, input last_out, output ready);
endinterface

`default_nettype wire

// ===== design/abx_front.sv =====
// Front end: accepts input bytes into the lookahead window and settles the head of the window.
// Emits literal and expansion tokens; depends on abx_pkg and abx_if.
`default_nettype none

module abx_front #(
  parameter int LONGEST_ABBREV = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  abx_in_if.sink                in_ch,
  output abx_pkg::abx_tok_t     tok,
  output logic                  tok_valid,
  input  wire logic             tok_ready
);

  localparam int WIN_DEPTH = LONGEST_ABBREV + 1;
  localparam int IW        = $clog2(WIN_DEPTH);
  localparam int CW        = $clog2(WIN_DEPTH + 1);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  logic                        state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        prev_r, prev_nxt;
  logic                        last_r, last_nxt;
  logic [7:0]                  win_r   [WIN_DEPTH];
  logic [7:0]                  win_nxt [WIN_DEPTH];
  abx_pkg::abx_judge_t         jd;
  logic [abx_pkg::POS_W-1:0]   drop;
  logic [CW-1:0]               count_after;

  always_comb begin
    logic                      found;
    logic                      eq;
    logic [abx_pkg::POS_W-1:0] len;
    jd    = '0;
    found = 1'b0;
    eq    = 1'b0;
    len   = '0;
    if (!prev_r) begin
      for (int k = 0; k < abx_pkg::NUM_ABBREV; k++) begin
        if (!found) begin
          len = abx_pkg::ABBR_LEN[k];
          eq  = 1'b1;
          for (int j = 0; j < abx_pkg::ABBR_MAX; j++) begin
            if (j < int'(len) && j < int'(count_r) &&
                win_r[j] != abx_pkg::abbr_char(abx_pkg::IDX_W'(k), abx_pkg::POS_W'(j))) begin
              eq = 1'b0;
            end
          end
          if (eq) begin
            if (count_r < CW'(len)) begin
              if (!last_r) begin
                jd.undecided = 1'b1;
                found        = 1'b1;
              end
            end else if (count_r == CW'(len)) begin
              found = 1'b1;
              if (last_r) begin
                jd.hit = 1'b1;
                jd.idx = abx_pkg::IDX_W'(k);
              end else begin
                jd.undecided = 1'b1;
              end
            end else if (!abx_pkg::is_alnum(win_r[IW'(len)])) begin
              found  = 1'b1;
              jd.hit = 1'b1;
              jd.idx = abx_pkg::IDX_W'(k);
            end
          end
        end
      end
    end
  end

  assign drop        = jd.hit ? abx_pkg::ABBR_LEN[jd.idx] : abx_pkg::POS_W'(1);
  assign count_after = count_r - CW'(drop);

  assign tok_valid   = (state_r == ST_RESOLVE) && !jd.undecided;
  assign tok.expand  = jd.hit;
  assign tok.data    = jd.hit ? 8'(jd.idx) : win_r[0];
  assign tok.last    = last_r && (count_after == '0);
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    prev_nxt  = prev_r;
    last_nxt  = last_r;
    win_nxt   = win_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          win_nxt[IW'(count_r)] = in_ch.char_in;
          count_nxt             = count_r + CW'(1);
          last_nxt              = in_ch.last_in;
          state_nxt             = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (jd.undecided) begin
          state_nxt = ST_IDLE;
        end else if (tok_ready) begin
          for (int i = 0; i < WIN_DEPTH; i++) begin
            if (i + int'(drop) < WIN_DEPTH) begin
              win_nxt[i] = win_r[IW'(i + int'(drop))];
            end
          end
          count_nxt = count_after;
          prev_nxt  = jd.hit ? 1'b0 : abx_pkg::is_alnum(win_r[0]);
          if (count_after == '0) begin
            state_nxt = ST_IDLE;
            if (last_r) begin
              prev_nxt = 1'b0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      prev_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WIN_DEPTH))
    else $error("lookahead window holds more bytes than it has room for");

  a_last_settles: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE && last_r) |-> !jd.undecided)
    else $error("window head left undecided while flushing the last byte");

  a_resolve_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) |-> (count_r != '0))
    else $error("resolving an empty window");

  a_string_end: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_valid && tok_ready && tok.last) |=>
      (count_r == '0 && !prev_r && state_r == ST_IDLE))
    else $error("window not cleared after the final token of a string");

endmodule

`default_nettype wire

// ===== design/abx_queue.sv =====
// Short token queue between the front end and the back end.
// Register based, QUEUE_DEPTH entries; depends on abx_pkg.
`default_nettype none

module abx_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire abx_pkg::abx_tok_t push_tok,
  input  wire logic              push_valid,
  output logic                   push_ready,
  output abx_pkg::abx_tok_t      pop_tok,
  output logic                   pop_valid,
  input  wire logic              pop_ready
);

  localparam int AW = $clog2(abx_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(abx_pkg::QUEUE_DEPTH + 1);

  abx_pkg::abx_tok_t mem_r [abx_pkg::QUEUE_DEPTH];
  logic [AW-1:0]     wr_r, wr_nxt;
  logic [AW-1:0]     rd_r, rd_nxt;
  logic [NW-1:0]     num_r, num_nxt;
  logic              do_push, do_pop;

  assign push_ready = (num_r != NW'(abx_pkg::QUEUE_DEPTH));
  assign pop_valid  = (num_r != '0);
  assign pop_tok    = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    num_nxt = num_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(abx_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(abx_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      num_nxt = num_r + NW'(1);
    end else if (do_pop && !do_push) begin
      num_nxt = num_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      num_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      num_r <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

// ===== design/abx_back.sv =====
// Back end: turns tokens into output bytes, spelling out expansions one byte per cycle while out_ch is ready.
// Drives the registered result channel; depends on abx_pkg and abx_if.
`default_nettype none

module abx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire abx_pkg::abx_tok_t q_tok,
  input  wire logic              q_valid,
  output logic                   q_ready,
  abx_out_if.source              out_ch
);

  abx_pkg::abx_tok_t           cur_r, cur_nxt;
  logic                        cur_vld_r, cur_vld_nxt;
  logic [abx_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [7:0]                  out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [abx_pkg::IDX_W-1:0]   idx;
  logic                        emit, fin;
  logic [7:0]                  next_byte;

  assign idx       = cur_r.data[abx_pkg::IDX_W-1:0];
  assign emit      = cur_vld_r && (!out_vld_r || out_ch.ready);
  assign fin       = !cur_r.expand ||
                     (pos_r == abx_pkg::FULL_LEN[idx] - abx_pkg::POS_W'(1));
  assign next_byte = cur_r.expand ? abx_pkg::full_char(idx, pos_r) : cur_r.data;
  assign q_ready   = !cur_vld_r || (emit && fin);

  always_comb begin
    cur_nxt      = cur_r;
    cur_vld_nxt  = cur_vld_r;
    pos_nxt      = pos_r;
    out_vld_nxt  = out_vld_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    if (emit) begin
      out_vld_nxt  = 1'b1;
      out_char_nxt = next_byte;
      out_last_nxt = cur_r.last && fin;
      pos_nxt      = fin ? '0 : pos_r + abx_pkg::POS_W'(1);
      if (fin) begin
        cur_vld_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (q_valid && q_ready) begin
      cur_nxt     = q_tok;
      cur_vld_nxt = 1'b1;
      pos_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
      pos_r     <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last_out = out_last_r;

endmodule

`default_nettype wire

// ===== design/abbreviation_expander_unit.sv =====
// Abbreviation expander top level: front end, token queue and back end.
// A byte that settles at once passes the window, queue, back-end token register and output register.
// No input is taken while the window head resolves or the queue is full; the back end emits
// one result byte per cycle while out_ch is ready, spelling expansions of up to 13 bytes.
// Reset: synchronous active-low rst_n empties the window, queue and output register.
`default_nettype none

module abbreviation_expander_unit #(
  parameter int LONGEST_ABBREV = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  abx_in_if.sink    in_ch,
  abx_out_if.source out_ch
);

  abx_pkg::abx_tok_t front_tok;
  logic              front_valid, front_ready;
  abx_pkg::abx_tok_t back_tok;
  logic              back_valid, back_ready;

  abx_front #(
    .LONGEST_ABBREV(LONGEST_ABBREV)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .tok       (front_tok),
    .tok_valid (front_valid),
    .tok_ready (front_ready)
  );

  abx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_tok   (front_tok),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_tok    (back_tok),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  abx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_tok   (back_tok),
    .q_valid (back_valid),
    .q_ready (back_ready),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_abbreviation_expander_unit.sv =====
// Self-checking testbench for abbreviation_expander_unit: directed and random strings.
// Predicts each expanded byte in-line and checks every out_ch transfer against it.
// Depends on design/abx_pkg.sv, design/abx_if.sv and the top-level RTL.
module tb_abbreviation_expander_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_CAP          = 9;
  localparam int NUM_ABBR         = 9;
  localparam int MAX_STEP_BYTES   = 32;
  localparam int HEAD_UNDECIDED   = -2;
  localparam int HEAD_LITERAL     = -1;
  localparam int TOTAL_ITEMS      = 220;
  localparam int HOLD_CYCLES      = 300;
  localparam int HOLD_AFTER       = 90;
  localparam int DRAIN_CYCLES     = 20;
  localparam int TIMEOUT_CYCLES   = 1000000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  string abbr_short [NUM_ABBR] = '{
    "facsims.", "facsim.", "ports.", "port.", "ill.", "col.", "ed.", "v.", "p."
  };
  string full_text [NUM_ABBR] = '{
    "facsimiles", "facsimile", "portraits", "portrait", "illustrations",
    "color", "edition", "volumes", "pages"
  };
  string separators = " ,;:()-/.[]'!?";

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  abx_in_if  in_if ();
  abx_out_if out_if ();

  abbreviation_expander_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_byte_t pending_items [$];
  text_byte_t expected_bytes [$];
  text_byte_t step_bytes [$];

  logic [7:0] win [WIN_CAP];
  int         win_cnt = 0;
  bit         prev_word = 1'b0;

  int  mismatch_count = 0;
  int  bytes_in = 0;
  int  strings_in = 0;
  int  bytes_out = 0;
  int  cycle_count = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  int  hold_left = 0;
  int  seen_in = 0;
  bit  pressed = 1'b0;
  logic hold_off = 1'b0;
  text_byte_t next_item;
  text_byte_t want;

  initial begin
    in_if.valid   = 1'b0;
    in_if.char_in = 8'h00;
    in_if.last_in = 1'b0;
    out_if.ready  = 1'b0;
  end

  function automatic bit alnum_byte(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic int judge_head(bit last);
    int k;
    int j;
    int len;
    int avail;
    bit same;
    if (prev_word) return HEAD_LITERAL;
    for (k = 0; k < NUM_ABBR; k++) begin
      len   = abbr_short[k].len();
      avail = (win_cnt < len) ? win_cnt : len;
      same  = 1'b1;
      for (j = 0; j < avail; j++) begin
        if (win[j] != 8'(abbr_short[k][j])) same = 1'b0;
      end
      if (!same) continue;
      if (win_cnt < len) begin
        if (last) continue;
        return HEAD_UNDECIDED;
      end
      if (win_cnt == len) begin
        if (last) return k;
        return HEAD_UNDECIDED;
      end
      if (!alnum_byte(win[len])) return k;
    end
    return HEAD_LITERAL;
  endfunction

  task automatic add_step_byte(logic [7:0] c);
    text_byte_t b;
    b.ch   = c;
    b.last = 1'b0;
    if (step_bytes.size() < MAX_STEP_BYTES) step_bytes.insert(step_bytes.size(), b);
  endtask

  task automatic drop_head(int count);
    int i;
    if (count > win_cnt) count = win_cnt;
    for (i = 0; i < win_cnt - count; i++) win[i] = win[i + count];
    win_cnt = win_cnt - count;
  endtask

  task automatic predict_transfer(logic [7:0] c, logic last);
    int verdict;
    int i;
    step_bytes.delete();
    if (win_cnt >= WIN_CAP) win_cnt = WIN_CAP - 1;
    win[win_cnt] = c;
    win_cnt++;
    while (win_cnt > 0) begin
      verdict = judge_head(last);
      if (verdict == HEAD_UNDECIDED) break;
      if (verdict >= 0) begin
        for (i = 0; i < full_text[verdict].len(); i++) add_step_byte(full_text[verdict][i]);
        drop_head(abbr_short[verdict].len());
        prev_word = 1'b0;
      end else begin
        add_step_byte(win[0]);
        prev_word = alnum_byte(win[0]);
        drop_head(1);
      end
    end
    if (last) begin
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
      win_cnt   = 0;
      prev_word = 1'b0;
    end
    foreach (step_bytes[i]) expected_bytes.insert(expected_bytes.size(), step_bytes[i]);
  endtask

  task automatic queue_byte(logic [7:0] c, logic last);
    text_byte_t b;
    b.ch   = c;
    b.last = last;
    pending_items.insert(pending_items.size(), b);
  endtask

  task automatic queue_text(string s, bit last_at_end);
    int i;
    for (i = 0; i < s.len(); i++) queue_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] random_alnum();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return 8'($urandom_range(8'h30, 8'h39));
    if (pick == 1) return 8'($urandom_range(8'h41, 8'h5a));
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [7:0] random_separator();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 8'(separators[$urandom_range(0, separators.len() - 1)]);
    if (pick < 8) return 8'($urandom_range(8'h80, 8'hff));
    return 8'($urandom_range(8'h00, 8'h1f));
  endfunction

  // Strings mix whole abbreviations (the most frequent pick), separators, words, cut-off
  // abbreviations and raw bytes mixed in.
  task automatic queue_random_string();
    logic [7:0] body [$];
    int n_tok;
    int t;
    int k;
    int j;
    int len;
    int pick;
    n_tok = $urandom_range(1, 6);
    for (t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, NUM_ABBR - 1);
      if (pick < 40) begin
        for (j = 0; j < abbr_short[k].len(); j++) body.insert(body.size(), abbr_short[k][j]);
      end else if (pick < 50) begin
        len = $urandom_range(1, abbr_short[k].len() - 1);
        for (j = 0; j < len; j++) body.insert(body.size(), abbr_short[k][j]);
      end else if (pick < 75) begin
        body.insert(body.size(), random_separator());
      end else if (pick < 90) begin
        len = $urandom_range(1, 4);
        for (j = 0; j < len; j++) body.insert(body.size(), random_alnum());
      end else begin
        body.insert(body.size(), 8'($urandom_range(0, 255)));
      end
    end
    foreach (body[j]) queue_byte(body[j], j == body.size() - 1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.char_in <= 8'h00;
      in_if.last_in <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_transfer(in_if.char_in, in_if.last_in);
        bytes_in++;
        if (in_if.last_in) strings_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_if.valid   <= 1'b1;
          in_if.char_in <= next_item.ch;
          in_if.last_in <= next_item.last;
          if (pending_items.size() % 30 == 0) tx_calm = ($urandom_range(0, 2) == 0);
          tx_wait = draw_gap(tx_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bytes_out++;
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing expected: char %h last %b",
                   $time, out_if.char_out, out_if.last_out);
        end else begin
          want = expected_bytes.pop_front();
          if (want.ch !== out_if.char_out || want.last !== out_if.last_out) begin
            mismatch_count++;
            $display("%0t: expected char %h last %b, got char %h last %b", $time,
                     want.ch, want.last, out_if.char_out, out_if.last_out);
          end
        end
        if (bytes_out % 30 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        rx_wait = draw_gap(rx_calm);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !hold_off;
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering bytes.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
      hold_left = 0;
      seen_in   = 0;
    end else begin
      if (in_if.valid && in_if.ready) seen_in++;
      if (!pressed && seen_in >= HOLD_AFTER) begin
        pressed   = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_off <= 1'b1;
      end else begin
        hold_off <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    queue_text("facsims.", 1'b1);
    queue_text("xv.", 1'b1);
    queue_text("v.9", 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_text("p.", 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_text("ill. p", 1'b1);
    while (pending_items.size() < TOTAL_ITEMS) queue_random_string();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_if.valid) @(negedge clk);
    while (expected_bytes.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d strings (%0d bytes), received %0d expanded bytes, %0d mismatches.",
             strings_in, bytes_in, bytes_out, mismatch_count);
    $display("Covered every abbreviation, cut-off forms, high-bit bytes and a long output stall.");
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
